>>> rtl/core/smeng_pkg.sv
// Shared types and constants for the stable matching engine.
// Used by the channel interfaces, the controller, the datapath and the checker.
package smeng_pkg;

  localparam int FIELD_W        = 5;
  localparam int DEF_MAX_PEOPLE = 16;

  localparam logic [FIELD_W-1:0] PEOPLE_RESET = 5'd16;

  localparam logic CMD_MAN   = 1'b0;
  localparam logic CMD_WOMAN = 1'b1;

  // Actions that the controller asks of the datapath.
  typedef struct packed {
    logic load;
    logic start;
    logic fill;
    logic pop;
    logic pref;
    logic rank;
    logic emit;
  } smeng_cmd_t;

  // Conditions that the datapath reports back to the controller.
  typedef struct packed {
    logic fill_done;
    logic q_empty;
    logic skip;
    logic w_reject;
    logic w_free;
    logic out_free;
    logic emit_done;
  } smeng_sts_t;

endpackage

>>> rtl/core/smeng_ifs.sv
// Valid/ready channel interfaces for load items and matched pairs.
// Depends on smeng_pkg for the field width.
interface smeng_item_if import smeng_pkg::*;;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [FIELD_W-1:0] person;
  logic [FIELD_W-1:0] position;
  logic [FIELD_W-1:0] choice;
  logic               last;

  modport source (output valid, cmd, person, position, choice, last, input ready);
  modport sink   (input valid, cmd, person, position, choice, last, output ready);
endinterface

interface smeng_pair_if import smeng_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] man;
  logic [FIELD_W-1:0] wife;
  logic               last_pair;

  modport source (output valid, man, wife, last_pair, input ready);
  modport sink   (input valid, man, wife, last_pair, output ready);
endinterface

>>> rtl/core/smeng_ctrl.sv
// Controller state machine of the stable matching engine.
// Depends on smeng_pkg for the command and status structs.
module smeng_ctrl import smeng_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_ready,
  input  smeng_sts_t sts,
  output smeng_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_POP,
    S_PREF,
    S_RANK,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.start  = 1'b1;
            state_next = S_FILL;
          end
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (sts.fill_done) begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        if (sts.q_empty) begin
          state_next = S_EMIT;
        end else begin
          cmd.pop = 1'b1;
          if (!sts.skip) begin
            state_next = S_PREF;
          end
        end
      end
      S_PREF: begin
        cmd.pref = 1'b1;
        if (sts.w_reject) begin
          state_next = S_POP;
        end else if (sts.w_free) begin
          state_next = S_POP;
        end else begin
          state_next = S_RANK;
        end
      end
      S_RANK: begin
        cmd.rank   = 1'b1;
        state_next = S_POP;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_done) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/core/smeng_dp.sv
// Datapath of the stable matching engine: preference memories, free-man queue,
// engagement registers and the result register. Depends on smeng_pkg.
module smeng_dp import smeng_pkg::*; #(
  parameter int MAX_PEOPLE = DEF_MAX_PEOPLE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [FIELD_W-1:0] cfg_data,
  input  smeng_cmd_t         cmd,
  output smeng_sts_t         sts,
  input  logic               in_cmd,
  input  logic [FIELD_W-1:0] in_person,
  input  logic [FIELD_W-1:0] in_position,
  input  logic [FIELD_W-1:0] in_choice,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [FIELD_W-1:0] out_man,
  output logic [FIELD_W-1:0] out_wife,
  output logic               out_last_pair
);

  localparam int IDX_W  = $clog2(MAX_PEOPLE);
  localparam int CNT_W  = $clog2(MAX_PEOPLE + 1);
  localparam int DEPTH  = MAX_PEOPLE * MAX_PEOPLE;
  localparam int ADDR_W = $clog2(DEPTH);

  function automatic logic [ADDR_W-1:0] tab_addr(input int row, input int col);
    return ADDR_W'(row * MAX_PEOPLE + col);
  endfunction

  function automatic logic [IDX_W-1:0] wrap_idx(input int v);
    return (v >= MAX_PEOPLE) ? IDX_W'(v - MAX_PEOPLE) : IDX_W'(v);
  endfunction

  // Configuration and clamped people count.
  logic [FIELD_W-1:0] people_count;
  logic [CNT_W-1:0]   n;

  always_ff @(posedge clk) begin
    if (rst) begin
      people_count <= PEOPLE_RESET;
    end else if (cfg_we) begin
      people_count <= cfg_data;
    end
  end

  always_comb begin
    if (people_count == '0) begin
      n = CNT_W'(1);
    end else if (int'(people_count) > MAX_PEOPLE) begin
      n = CNT_W'(MAX_PEOPLE);
    end else begin
      n = CNT_W'(people_count);
    end
  end

  // Preference memories.
  logic [FIELD_W-1:0] man_pref_mem [DEPTH];
  logic [FIELD_W-1:0] rank_mem     [DEPTH];
  logic [FIELD_W-1:0] pref_q;
  logic [FIELD_W-1:0] rank_m_q;
  logic [FIELD_W-1:0] rank_f_q;
  logic               load_ok;
  logic [ADDR_W-1:0]  man_wr_addr;
  logic [ADDR_W-1:0]  rank_wr_addr;
  logic [ADDR_W-1:0]  pref_rd_addr;
  logic [ADDR_W-1:0]  rank_addr_m;
  logic [ADDR_W-1:0]  rank_addr_f;

  assign load_ok = (in_person != '0) && (int'(in_person) <= MAX_PEOPLE) &&
                   (in_position != '0) && (int'(in_position) <= MAX_PEOPLE) &&
                   (in_choice != '0) && (int'(in_choice) <= MAX_PEOPLE);
  assign man_wr_addr  = tab_addr(int'(in_person) - 1, int'(in_position) - 1);
  assign rank_wr_addr = tab_addr(int'(in_person) - 1, int'(in_choice) - 1);

  // Free-man queue and per-person state.
  logic [CNT_W-1:0] q_mem   [MAX_PEOPLE];
  logic [CNT_W-1:0] next_prop [MAX_PEOPLE];
  logic [CNT_W-1:0] fiance  [MAX_PEOPLE];
  logic [CNT_W-1:0] wife_of [MAX_PEOPLE];
  logic [IDX_W-1:0] q_head;
  logic [CNT_W-1:0] q_count;
  logic [IDX_W-1:0] q_tail;
  logic [CNT_W-1:0] fill_cnt;
  logic [CNT_W-1:0] emit_idx;
  logic [CNT_W-1:0] cur_m;
  logic [CNT_W-1:0] cur_w;
  logic [CNT_W-1:0] cur_f;

  logic             push_en;
  logic [CNT_W-1:0] push_val;

  // Proposal step signals.
  logic [CNT_W-1:0] q_top;
  logic [IDX_W-1:0] m_idx;
  logic [CNT_W-1:0] np_m;
  logic             m_ok;
  logic             skip;
  logic [IDX_W-1:0] w_idx;
  logic [CNT_W-1:0] w_cur;
  logic             w_reject;
  logic             w_free;
  logic             better;
  logic [IDX_W-1:0] cur_m_idx;
  logic [IDX_W-1:0] cur_w_idx;

  // Emission signals.
  logic [IDX_W-1:0] e_idx;
  logic [CNT_W-1:0] e_wife;
  logic [IDX_W-1:0] e_wife_idx;
  logic             e_has_wife;

  assign q_tail   = wrap_idx(int'(q_head) + int'(q_count));
  assign q_top    = q_mem[q_head];
  assign m_idx    = IDX_W'(int'(q_top) - 1);
  assign np_m     = next_prop[m_idx];
  assign m_ok     = (q_top != '0) && (q_top <= n);
  assign skip     = !m_ok || (np_m >= n);
  assign pref_rd_addr = tab_addr(int'(m_idx), int'(np_m));

  assign w_reject = (pref_q == '0) || (int'(pref_q) > int'(n));
  assign w_idx    = IDX_W'(int'(pref_q) - 1);
  assign w_cur    = fiance[w_idx];
  assign w_free   = (w_cur == '0);
  assign rank_addr_m = tab_addr(int'(w_idx), int'(cur_m) - 1);
  assign rank_addr_f = tab_addr(int'(w_idx), int'(w_cur) - 1);

  // The woman keeps her fiance when the ranks are equal.
  assign better    = (cur_f <= n) && (rank_m_q < rank_f_q);
  assign cur_m_idx = IDX_W'(int'(cur_m) - 1);
  assign cur_w_idx = IDX_W'(int'(cur_w) - 1);

  assign e_idx      = IDX_W'(int'(emit_idx) - 1);
  assign e_wife     = wife_of[e_idx];
  assign e_wife_idx = IDX_W'(int'(e_wife) - 1);
  // A recorded wife counts only if she is still engaged to this man.
  assign e_has_wife = (e_wife != '0) && (fiance[e_wife_idx] == emit_idx);

  always_comb begin
    push_en  = 1'b0;
    push_val = cur_m;
    if (cmd.fill) begin
      push_en  = 1'b1;
      push_val = CNT_W'(int'(fill_cnt) + 1);
    end else if (cmd.pref && w_reject) begin
      push_en  = 1'b1;
    end else if (cmd.rank) begin
      push_en  = 1'b1;
      push_val = better ? cur_f : cur_m;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && load_ok && (in_cmd == CMD_MAN)) begin
      man_pref_mem[man_wr_addr] <= in_choice;
    end
    if (cmd.pop) begin
      pref_q <= man_pref_mem[pref_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && load_ok && (in_cmd == CMD_WOMAN)) begin
      rank_mem[rank_wr_addr] <= in_position;
    end
    if (cmd.pref) begin
      rank_m_q <= rank_mem[rank_addr_m];
      rank_f_q <= rank_mem[rank_addr_f];
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      q_mem[q_tail] <= push_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_head   <= '0;
      q_count  <= '0;
      fill_cnt <= '0;
      emit_idx <= CNT_W'(1);
    end else if (cmd.start) begin
      q_head   <= '0;
      q_count  <= '0;
      fill_cnt <= '0;
      emit_idx <= CNT_W'(1);
    end else begin
      if (cmd.fill) begin
        fill_cnt <= CNT_W'(int'(fill_cnt) + 1);
      end
      if (cmd.pop) begin
        q_head  <= wrap_idx(int'(q_head) + 1);
        q_count <= CNT_W'(int'(q_count) - 1);
      end else if (push_en) begin
        q_count <= CNT_W'(int'(q_count) + 1);
      end
      if (cmd.emit) begin
        emit_idx <= CNT_W'(int'(emit_idx) + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < MAX_PEOPLE; i++) begin
        next_prop[i] <= '0;
        fiance[i]    <= '0;
        wife_of[i]   <= '0;
      end
    end else begin
      if (cmd.pop) begin
        cur_m <= q_top;
        if (!skip) begin
          next_prop[m_idx] <= CNT_W'(int'(np_m) + 1);
        end
      end
      if (cmd.pref && !w_reject) begin
        cur_w <= CNT_W'(pref_q);
        cur_f <= w_cur;
        if (w_free) begin
          fiance[w_idx]      <= cur_m;
          wife_of[cur_m_idx] <= CNT_W'(pref_q);
        end
      end
      if (cmd.rank && better) begin
        fiance[cur_w_idx]  <= cur_m;
        wife_of[cur_m_idx] <= cur_w;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_man       <= FIELD_W'(emit_idx);
      out_wife      <= e_has_wife ? FIELD_W'(e_wife) : '0;
      out_last_pair <= (emit_idx == n);
    end
  end

  always_comb begin
    sts.fill_done = (int'(fill_cnt) + 1 == int'(n));
    sts.q_empty   = (q_count == '0);
    sts.skip      = skip;
    sts.w_reject  = w_reject;
    sts.w_free    = w_free;
    sts.out_free  = !out_valid || out_ready;
    sts.emit_done = (emit_idx == n);
  end

endmodule

>>> rtl/core/stable_matching_engine.sv
// Stable matching engine, top level: man-proposing stable marriage.
// Load items are taken one per cycle while the engine is idle. The item flagged last
// starts a matching that queues the men, passes over each skipped man, and runs each
// proposal as a queue pop, a list read and, if the woman is engaged, a rank compare,
// with at most n*n proposals; it then emits one pair per man. Synchronous reset
// clears control and the queue, sets people_count to 16 and leaves the preference memories unwritten.
module stable_matching_engine import smeng_pkg::*; #(
  parameter int MAX_PEOPLE = DEF_MAX_PEOPLE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [FIELD_W-1:0] cfg_data,
  smeng_item_if.sink         items,
  smeng_pair_if.source       pairs
);

  smeng_cmd_t cmd;
  smeng_sts_t sts;

  smeng_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_last  (items.last),
    .in_ready (items.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  smeng_dp #(
    .MAX_PEOPLE (MAX_PEOPLE)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .in_cmd        (items.cmd),
    .in_person     (items.person),
    .in_position   (items.position),
    .in_choice     (items.choice),
    .out_ready     (pairs.ready),
    .out_valid     (pairs.valid),
    .out_man       (pairs.man),
    .out_wife      (pairs.wife),
    .out_last_pair (pairs.last_pair)
  );

endmodule

>>> rtl/core/smeng_checker.sv
// Port-level checker for the stable matching engine and its bind statement.
// Depends on smeng_pkg and on the top level stable_matching_engine.
module smeng_checker import smeng_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_last,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FIELD_W-1:0] out_man,
  input logic [FIELD_W-1:0] out_wife,
  input logic               out_last_pair
);

  logic               in_xfer_last;
  logic               out_xfer;
  logic [FIELD_W-1:0] exp_man;
  logic [1:0]         owed;

  assign in_xfer_last = in_valid && in_ready && in_last;
  assign out_xfer     = out_valid && out_ready;

  // Men come out in order 1..n; a matching is owed for each last item taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_man <= FIELD_W'(1);
      owed    <= '0;
    end else begin
      if (out_xfer) begin
        exp_man <= out_last_pair ? FIELD_W'(1) : FIELD_W'(int'(exp_man) + 1);
      end
      if (in_xfer_last && !(out_xfer && out_last_pair)) begin
        owed <= owed + 2'd1;
      end else if (!in_xfer_last && out_xfer && out_last_pair) begin
        owed <= owed - 2'd1;
      end
    end
  end

  a_owed: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> (owed != 2'd0))
    else $error("pair transferred with no matching started");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> (out_man == exp_man))
    else $error("pairs out of man order");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer_last |=> !in_ready)
    else $error("load accepted right after matching start");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_man) &&
      $stable(out_wife) && $stable(out_last_pair))
    else $error("stalled pair changed");

endmodule

bind stable_matching_engine smeng_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (items.valid),
  .in_ready      (items.ready),
  .in_last       (items.last),
  .out_valid     (pairs.valid),
  .out_ready     (pairs.ready),
  .out_man       (pairs.man),
  .out_wife      (pairs.wife),
  .out_last_pair (pairs.last_pair)
);
